// ----- design/grc_pkg.sv -----
// grid ray caster package: item, config and result types, state codes, widths
// no dependencies; imported by every module of the block
package grc_pkg;

  localparam int MAP_SIDE    = 64;
  localparam int MAP_BITS    = 6;
  localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;
  localparam int FRAC_BITS   = 16;
  localparam int SCREEN_BITS = 12;
  localparam int STEP_GUARD  = 2 * MAP_SIDE;

  // shared divider widths, side distance and delta widths
  localparam int NUM_W  = 40;
  localparam int DEN_W  = 36;
  localparam int SD_W   = 41;
  localparam int DELTA_W = 32;

  localparam logic [DELTA_W-1:0] DELTA_MAX = '1;
  localparam logic [23:0] PERP_MAX = 24'hFFFFFF;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_CAST  = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    REG_PLAYER_X   = 3'd0,
    REG_PLAYER_Y   = 3'd1,
    REG_VIEW_DIR_X = 3'd2,
    REG_VIEW_DIR_Y = 3'd3,
    REG_PLANE_X    = 3'd4,
    REG_PLANE_Y    = 3'd5,
    REG_WIDTH      = 3'd6,
    REG_HEIGHT     = 3'd7
  } cfg_index_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [11:0] column;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic        wall_bit;
  } item_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [18:0] view_dir_x;
    logic signed [18:0] view_dir_y;
    logic signed [18:0] cam_plane_x;
    logic signed [18:0] cam_plane_y;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic        escaped;
    logic [5:0]  hit_col;
    logic [5:0]  hit_row;
    logic [11:0] draw_end;
    logic [11:0] draw_start;
    logic [15:0] line_height;
    logic [23:0] perp_distance;
    logic        hit_side;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CAM, S_MULX, S_MULY, S_RAY,
    S_DX, S_DX_WAIT, S_DY, S_DY_WAIT, S_SIDE_X, S_SIDE_Y,
    S_STEP, S_CHECK, S_PERP, S_PERP_WAIT, S_LH, S_LH_WAIT, S_ROWS, S_OUT
  } state_t;

endpackage

// ----- design/grid_ray_caster_column.sv -----
// grid ray caster top level: stream ports, configuration registers
// depends on grc_pkg, grc_queue, grc_engine
//
// usage
//   input stream s_axis: tuser is the op (0 map write, 1 column cast), tdata
//   carries column, cell row, cell column and wall bit
//   a map write transaction stores one wall bit and gives no result
//   a cast transaction gives exactly one result transaction on m_axis
//   configuration: cfg_we with cfg_index/cfg_data writes one register per cycle;
//   the user writes only while the block is idle, the block does not enforce it
// operation
//   a map write is done by the back sequencer in its idle state
//   a cast runs up to five divisions on one shared divider (camera
//   coordinate, two inverse deltas, perpendicular distance, line height)
//   and walks the grid, each cell in a step state and then a check state
//   for the registered map store read; at most 128 cell steps, so the divider
//   and the walk set the rate
//   a two-entry queue lets input transactions arrive while a cast runs
// reset
//   rst clears the queue, sequencer and output valid and loads the default
//   configuration registers; the map store is not cleared and must be written first
// stall
//   a finished result waits in the output register while m_axis_tready is low;
//   the queue keeps accepting until it is full
module grid_ray_caster_column
  import grc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] column, [17:12] cell_row, [23:18] cell_col, [24] wall_bit, rest zero
  input  logic [31:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] hit_side, [24:1] perp_distance, [40:25] line_height, [52:41] draw_start,
  // [64:53] draw_end, [70:65] hit_row, [76:71] hit_col, [77] escaped, rest zero
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  cfg_t    cfg;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x      <= 22'd2129920;
      cfg.player_y      <= 22'd2129920;
      cfg.view_dir_x    <= 19'sd65536;
      cfg.view_dir_y    <= 19'sd0;
      cfg.cam_plane_x   <= 19'sd0;
      cfg.cam_plane_y   <= 19'sd43253;
      cfg.screen_width  <= 13'd640;
      cfg.screen_height <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_PLAYER_X:   cfg.player_x      <= cfg_data;
        REG_PLAYER_Y:   cfg.player_y      <= cfg_data;
        REG_VIEW_DIR_X: cfg.view_dir_x    <= cfg_data[18:0];
        REG_VIEW_DIR_Y: cfg.view_dir_y    <= cfg_data[18:0];
        REG_PLANE_X:    cfg.cam_plane_x   <= cfg_data[18:0];
        REG_PLANE_Y:    cfg.cam_plane_y   <= cfg_data[18:0];
        REG_WIDTH:      cfg.screen_width  <= cfg_data[12:0];
        REG_HEIGHT:     cfg.screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  grc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_data  (s_axis_tdata[24:0]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: map writes and ray casts
  grc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {2'b00, result};

endmodule

// ----- design/grc_queue.sv -----
// front part: accepts input transactions, classifies them, holds two in a queue
// depends on grc_pkg
module grc_queue
  import grc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [24:0] in_data,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item_in;
  logic       push;

  always_comb begin
    item_in.kind     = in_op ? KIND_CAST : KIND_WRITE;
    item_in.column   = in_data[11:0];
    item_in.cell_row = in_data[17:12];
    item_in.cell_col = in_data[23:18];
    item_in.wall_bit = in_data[24];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- design/grc_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on grc_pkg
module grc_div
  import grc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic             busy;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, nq[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      nq <= {nq[NUM_W-2:0], fits};
      if (fits) rem <= DEN_W'(shifted - {1'b0, dvs});
      else rem <= shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/grc_engine.sv -----
// back part: map store writes and the per-column ray cast sequencer
// depends on grc_pkg and grc_div
module grc_engine
  import grc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  state_t state, state_next;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  logic             mem [MAP_CELLS];
  logic             rd_bit;
  logic             mem_we;
  logic             out_load;

  logic signed [30:0] cam;
  logic signed [49:0] prodx, prody;
  logic signed [35:0] rx, ry;
  logic [DEN_W-1:0]   rx_mag, ry_mag, rmag;
  logic [DELTA_W-1:0] ddx, ddy;
  logic [SD_W-1:0]    sdx, sdy;
  logic signed [7:0]  mx, my, nmx, nmy;
  logic [7:0]         steps;
  logic               side, esc, take_x, nxt_in;
  logic [23:0]        perp;
  logic [15:0]        lh;
  logic [11:0]        ds, de;
  logic [12:0]        w_eff, h_eff;
  logic [16:0]        frac_sel;
  logic [DELTA_W-1:0] delta_sel;
  logic [48:0]        side_prod;
  logic signed [23:0] numv;
  logic [22:0]        num_mag;
  logic [11:0]        half;
  logic [14:0]        lh2;
  logic [16:0]        de_sum;
  result_t            res_next;

  grc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign w_eff  = (cfg.screen_width == '0) ? 13'd1 : cfg.screen_width;
  assign h_eff  = (cfg.screen_height == '0) ? 13'd1 : cfg.screen_height;
  assign rx_mag = rx[35] ? DEN_W'(-rx) : DEN_W'(rx);
  assign ry_mag = ry[35] ? DEN_W'(-ry) : DEN_W'(ry);

  // one multiplier shared by the two initial side distances
  always_comb begin
    if (state == S_SIDE_X) begin
      frac_sel  = rx[35] ? {1'b0, cfg.player_x[15:0]} : 17'h10000 - {1'b0, cfg.player_x[15:0]};
      delta_sel = ddx;
    end else begin
      frac_sel  = ry[35] ? {1'b0, cfg.player_y[15:0]} : 17'h10000 - {1'b0, cfg.player_y[15:0]};
      delta_sel = ddy;
    end
    side_prod = 49'(frac_sel) * 49'(delta_sel);
  end

  // next cell of the walk, ties go to the y step
  always_comb begin
    take_x = sdx < sdy;
    nmx    = mx;
    nmy    = my;
    if (take_x) nmx = mx + (rx[35] ? -8'sd1 : 8'sd1);
    else nmy = my + (ry[35] ? -8'sd1 : 8'sd1);
    nxt_in = (nmx[7:6] == 2'b00) && (nmy[7:6] == 2'b00);
  end

  // distance along the axis of the hit line
  always_comb begin
    if (!side) begin
      numv = $signed({2'b00, mx[5:0], 16'h0000}) - $signed({2'b00, cfg.player_x})
           + (rx[35] ? 24'sh010000 : 24'sh000000);
      rmag = rx_mag;
    end else begin
      numv = $signed({2'b00, my[5:0], 16'h0000}) - $signed({2'b00, cfg.player_y})
           + (ry[35] ? 24'sh010000 : 24'sh000000);
      rmag = ry_mag;
    end
    num_mag = numv[23] ? 23'(-numv) : 23'(numv);
  end

  always_comb begin
    half   = h_eff[12:1];
    lh2    = lh[15:1];
    ds     = ({1'b0, lh2} > {4'b0000, half}) ? 12'd0 : 12'({4'b0000, half} - {1'b0, lh2});
    de_sum = {2'b00, lh2} + {5'b00000, half};
    if (de_sum >= {4'b0000, h_eff}) de_sum = {4'b0000, h_eff} - 17'd1;
    de     = (de_sum > 17'd4095) ? 12'd4095 : de_sum[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_CAST) begin
            div_start  = 1'b1;
            div_num    = {11'b0, q_item.column, 17'b0};
            div_den    = {23'b0, w_eff};
            state_next = S_CAM;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_CAM:  if (div_done) state_next = S_MULX;
      S_MULX: state_next = S_MULY;
      S_MULY: state_next = S_RAY;
      S_RAY:  state_next = S_DX;
      S_DX: begin
        if (rx == '0) state_next = S_DY;
        else begin
          div_start  = 1'b1;
          div_num    = {7'b0, 1'b1, 32'b0};
          div_den    = rx_mag;
          state_next = S_DX_WAIT;
        end
      end
      S_DX_WAIT: if (div_done) state_next = S_DY;
      S_DY: begin
        if (ry == '0) state_next = S_SIDE_X;
        else begin
          div_start  = 1'b1;
          div_num    = {7'b0, 1'b1, 32'b0};
          div_den    = ry_mag;
          state_next = S_DY_WAIT;
        end
      end
      S_DY_WAIT: if (div_done) state_next = S_SIDE_X;
      S_SIDE_X:  state_next = S_SIDE_Y;
      S_SIDE_Y:  state_next = S_STEP;
      S_STEP: begin
        if (steps == 8'(STEP_GUARD) || !nxt_in) state_next = S_OUT;
        else state_next = S_CHECK;
      end
      S_CHECK: state_next = rd_bit ? S_PERP : S_STEP;
      S_PERP: begin
        if (rmag == '0) state_next = S_LH;
        else begin
          div_start  = 1'b1;
          div_num    = {1'b0, num_mag, 16'b0};
          div_den    = rmag;
          state_next = S_PERP_WAIT;
        end
      end
      S_PERP_WAIT: if (div_done) state_next = S_LH;
      S_LH: begin
        if (perp == '0) state_next = S_ROWS;
        else begin
          div_start  = 1'b1;
          div_num    = {11'b0, h_eff, 16'b0};
          div_den    = {12'b0, perp};
          state_next = S_LH_WAIT;
        end
      end
      S_LH_WAIT: if (div_done) state_next = S_ROWS;
      S_ROWS:    state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // map store: one write port, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[{q_item.cell_row, q_item.cell_col}] <= q_item.wall_bit;
    rd_bit <= mem[{nmy[5:0], nmx[5:0]}];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CAM:  if (div_done) cam <= $signed({1'b0, div_quo[29:0]}) - 31'sd65536;
      S_MULX: prodx <= cfg.cam_plane_x * cam;
      S_MULY: prody <= cfg.cam_plane_y * cam;
      S_RAY: begin
        rx    <= 36'(cfg.view_dir_x) + 36'(prodx >>> FRAC_BITS);
        ry    <= 36'(cfg.view_dir_y) + 36'(prody >>> FRAC_BITS);
        mx    <= {2'b00, cfg.player_x[21:16]};
        my    <= {2'b00, cfg.player_y[21:16]};
        steps <= '0;
        esc   <= 1'b0;
        side  <= 1'b0;
      end
      S_DX:      if (rx == '0) ddx <= DELTA_MAX;
      S_DX_WAIT: if (div_done) ddx <= (div_quo[39:32] != '0) ? DELTA_MAX : div_quo[31:0];
      S_DY:      if (ry == '0) ddy <= DELTA_MAX;
      S_DY_WAIT: if (div_done) ddy <= (div_quo[39:32] != '0) ? DELTA_MAX : div_quo[31:0];
      S_SIDE_X:  sdx <= SD_W'(side_prod >> FRAC_BITS);
      S_SIDE_Y:  sdy <= SD_W'(side_prod >> FRAC_BITS);
      S_STEP: begin
        if (steps == 8'(STEP_GUARD)) esc <= 1'b1;
        else begin
          steps <= steps + 8'd1;
          mx    <= nmx;
          my    <= nmy;
          if (take_x) begin
            sdx  <= sdx + SD_W'(ddx);
            side <= 1'b0;
          end else begin
            sdy  <= sdy + SD_W'(ddy);
            side <= 1'b1;
          end
          if (!nxt_in) esc <= 1'b1;
        end
      end
      S_PERP:      if (rmag == '0) perp <= PERP_MAX;
      S_PERP_WAIT: if (div_done) perp <= (div_quo[39:24] != '0) ? PERP_MAX : div_quo[23:0];
      S_LH:        if (perp == '0) lh <= LINE_MAX;
      S_LH_WAIT:   if (div_done) lh <= (div_quo[39:16] != '0) ? LINE_MAX : div_quo[15:0];
      default: ;
    endcase
  end

  // escaped rays report only the flag
  always_comb begin
    res_next = '0;
    if (esc) res_next.escaped = 1'b1;
    else begin
      res_next.hit_side      = side;
      res_next.perp_distance = perp;
      res_next.line_height   = lh;
      res_next.draw_start    = ds;
      res_next.draw_end      = de;
      res_next.hit_row       = my[5:0];
      res_next.hit_col       = mx[5:0];
    end
  end

  // result register parts the sequencer from the output stall
  always_ff @(posedge clk) begin
    if (out_load) out_result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule
